// File: hdl/baro_temp_pressure_compensation_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Clocked concurrent assertion wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// checked only outside reset
`define BPTC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// checked on every edge, reset included
`define BPTC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/bptc_pkg.sv
// ----------------------------------------------------------------------------
// bptc_pkg
// Types, widths and constants of the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

   localparam int RAW_W     = 20;
   localparam int TEMP_W    = 19;
   localparam int PRESS_W   = 32;
   localparam int WORD_W    = 64;
   localparam int DMAG_W    = 31;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_CAL   = 6;

   localparam int FRONT_STAGES = 10;
   localparam int DIV_STAGES   = WORD_W;
   localparam int BACK_STAGES  = 6;
   localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

   localparam int FINE_T_OFFSET = 128000;
   localparam int PRESS_BASE    = 1048576;
   localparam int PRESS_SCALE   = 3125;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_T1_T2 = 3'd0,
      CSR_T3_P1 = 3'd1,
      CSR_P2_P3 = 3'd2,
      CSR_P4_P5 = 3'd3,
      CSR_P6_P7 = 3'd4,
      CSR_P8_P9 = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_temperature;
      logic [RAW_W-1:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature_centi;
      logic [PRESS_W-1:0]       pressure_q24_8;
      logic                     divide_error;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic signed [15:0] t2;
      logic signed [15:0] t3;
      logic [15:0]        p1;
      logic signed [15:0] p2;
      logic signed [15:0] p3;
      logic signed [15:0] p4;
      logic signed [15:0] p5;
      logic signed [15:0] p6;
      logic signed [15:0] p7;
      logic signed [15:0] p8;
      logic signed [15:0] p9;
   } cal_type;

   typedef struct packed {
      logic                     valid;
      logic signed [TEMP_W-1:0] temp;
      logic                     err;
      logic                     neg;
      logic [WORD_W-1:0]        nmag;
      logic [DMAG_W-1:0]        dmag;
   } div_in_type;

   typedef struct packed {
      logic                     valid;
      logic signed [TEMP_W-1:0] temp;
      logic                     err;
      logic                     neg;
      logic [WORD_W-1:0]        quo;
   } div_out_type;

endpackage

// File: hdl/bptc_front.sv
// ----------------------------------------------------------------------------
// bptc_front
// Temperature compensation and pressure numerator / divisor, ten stages.
// ----------------------------------------------------------------------------
module bptc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  bptc_pkg::req_type    in_data,
   input  bptc_pkg::cal_type    cal,
   output bptc_pkg::div_in_type div_out
);
   import bptc_pkg::*;

   logic [RAW_W-1:0] rawp_ff [7];
   logic [9:1] v_ff;
   logic signed [TEMP_W-1:0] temp_ff [4:9];

   // stage 1
   logic signed [18:0] a_in;
   logic signed [17:0] b_in;
   logic signed [34:0] s1_at_ff, s1_at_in;
   logic signed [35:0] s1_bb_ff, s1_bb_in;
   // stage 2
   logic signed [23:0] s2_v1t_ff, s2_v1t_in, bb12;
   logic signed [39:0] s2_b3_ff, s2_b3_in;
   // stage 3
   logic signed [23:0] s3_tf_ff, s3_tf_in;
   // stage 4
   logic signed [26:0] t5;
   logic signed [24:0] s4_d_ff, s4_d_in;
   // stage 5
   logic signed [49:0] s5_dd_ff, s5_dd_in;
   logic signed [40:0] s5_dp5_ff, s5_dp5_in, s5_dp2_ff, s5_dp2_in;
   // stage 6
   logic signed [WORD_W-1:0] s6_ddp6_ff, s6_ddp6_in, s6_ddp3_ff, s6_ddp3_in;
   logic signed [40:0] s6_dp5_ff, s6_dp2_ff;
   // stage 7
   logic signed [WORD_W-1:0] s7_v2_ff, s7_v2_in, s7_v1a_ff, s7_v1a_in;
   // stage 8
   logic [20:0] pr;
   logic [47:0] s8_lo_ff, s8_lo_in;
   logic [31:0] s8_hi_ff, s8_hi_in;
   logic [WORD_W-1:0] s8_num0_ff, s8_num0_in;
   // stage 9
   logic [WORD_W-1:0] v1full;
   logic signed [DMAG_W-1:0] s9_v1_ff, s9_v1_in;
   logic [WORD_W-1:0] s9_num_ff, s9_num_in;
   // stage 10
   div_in_type s10_ff, s10_in;

   assign a_in = $signed({2'b0, in_data.raw_temperature[RAW_W-1:3]})
               - $signed({2'b0, cal.t1, 1'b0});
   assign b_in = $signed({2'b0, in_data.raw_temperature[RAW_W-1:4]})
               - $signed({2'b0, cal.t1});
   assign s1_at_in = a_in * $signed(cal.t2);
   assign s1_bb_in = b_in * b_in;

   assign s2_v1t_in = $signed(s1_at_ff[34:11]);
   assign bb12      = $signed(s1_bb_ff[35:12]);
   assign s2_b3_in  = bb12 * $signed(cal.t3);

   assign s3_tf_in = 24'(s2_v1t_ff + $signed(s2_b3_ff[39:14]));

   // (tfine * 5 + 128) >> 8
   assign t5      = 27'(s3_tf_ff) * 27'sd5 + 27'sd128;
   assign s4_d_in = 25'(s3_tf_ff) - 25'(FINE_T_OFFSET);

   assign s5_dd_in  = s4_d_ff * s4_d_ff;
   assign s5_dp5_in = s4_d_ff * $signed(cal.p5);
   assign s5_dp2_in = s4_d_ff * $signed(cal.p2);

   assign s6_ddp6_in = s5_dd_ff * $signed(cal.p6);
   assign s6_ddp3_in = s5_dd_ff * $signed(cal.p3);

   assign s7_v2_in  = s6_ddp6_ff + (64'(s6_dp5_ff) <<< 17)
                    + (64'($signed(cal.p4)) <<< 35);
   assign s7_v1a_in = (s6_ddp3_ff >>> 8) + (64'(s6_dp2_ff) <<< 12)
                    + 64'sh0000_8000_0000_0000;

   // 64-bit wrap of v1a * p1 from two partial products
   assign pr         = 21'(PRESS_BASE) - 21'(rawp_ff[6]);
   assign s8_lo_in   = s7_v1a_ff[31:0] * cal.p1;
   assign s8_hi_in   = 32'(s7_v1a_ff[63:32] * cal.p1);
   assign s8_num0_in = (64'(pr) << 31) - s7_v2_ff;

   assign v1full    = 64'(s8_lo_ff) + {s8_hi_ff, 32'b0};
   assign s9_v1_in  = $signed(v1full[63:33]);
   assign s9_num_in = s8_num0_ff * 64'(PRESS_SCALE);

   always_comb begin
      s10_in.valid = v_ff[9];
      s10_in.temp  = temp_ff[9];
      s10_in.err   = (s9_v1_ff == '0);
      s10_in.neg   = s9_num_ff[WORD_W-1] ^ s9_v1_ff[DMAG_W-1];
      s10_in.nmag  = s9_num_ff[WORD_W-1] ? (-s9_num_ff) : s9_num_ff;
      s10_in.dmag  = s9_v1_ff[DMAG_W-1] ? DMAG_W'(-s9_v1_ff) : s9_v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         s10_ff.valid <= 1'b0;
      end else begin
         v_ff         <= {v_ff[8:1], in_valid};
         s10_ff.valid <= s10_in.valid;
      end
      rawp_ff[0] <= in_data.raw_pressure;
      for (int i = 1; i < 7; i++) rawp_ff[i] <= rawp_ff[i-1];
      temp_ff[4] <= t5[26:8];
      for (int i = 5; i < 10; i++) temp_ff[i] <= temp_ff[i-1];
      s1_at_ff   <= s1_at_in;
      s1_bb_ff   <= s1_bb_in;
      s2_v1t_ff  <= s2_v1t_in;
      s2_b3_ff   <= s2_b3_in;
      s3_tf_ff   <= s3_tf_in;
      s4_d_ff    <= s4_d_in;
      s5_dd_ff   <= s5_dd_in;
      s5_dp5_ff  <= s5_dp5_in;
      s5_dp2_ff  <= s5_dp2_in;
      s6_ddp6_ff <= s6_ddp6_in;
      s6_ddp3_ff <= s6_ddp3_in;
      s6_dp5_ff  <= s5_dp5_ff;
      s6_dp2_ff  <= s5_dp2_ff;
      s7_v2_ff   <= s7_v2_in;
      s7_v1a_ff  <= s7_v1a_in;
      s8_lo_ff   <= s8_lo_in;
      s8_hi_ff   <= s8_hi_in;
      s8_num0_ff <= s8_num0_in;
      s9_v1_ff   <= s9_v1_in;
      s9_num_ff  <= s9_num_in;
      s10_ff.temp <= s10_in.temp;
      s10_ff.err  <= s10_in.err;
      s10_ff.neg  <= s10_in.neg;
      s10_ff.nmag <= s10_in.nmag;
      s10_ff.dmag <= s10_in.dmag;
   end

   assign div_out = s10_ff;

endmodule

// File: hdl/bptc_div.sv
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined restoring divider, one quotient bit per stage, magnitudes only.
// ----------------------------------------------------------------------------
module bptc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bptc_pkg::div_in_type  div_in,
   output bptc_pkg::div_out_type div_out
);
   import bptc_pkg::*;

   typedef struct packed {
      logic                     valid;
      logic signed [TEMP_W-1:0] temp;
      logic                     err;
      logic                     neg;
      logic [WORD_W-1:0]        nq;    // dividend bits shift out, quotient bits shift in
      logic [DMAG_W-1:0]        rem;
      logic [DMAG_W-1:0]        dmag;
   } stage_type;

   stage_type stg_ff [DIV_STAGES];
   stage_type first;

   always_comb begin
      first.valid = div_in.valid;
      first.temp  = div_in.temp;
      first.err   = div_in.err;
      first.neg   = div_in.neg;
      first.nq    = div_in.nmag;
      first.rem   = '0;
      first.dmag  = div_in.dmag;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      stage_type cur, nxt;
      logic [DMAG_W:0] trial;
      logic ge;

      if (k == 0) begin : g_first
         assign cur = first;
      end else begin : g_next
         assign cur = stg_ff[k-1];
      end

      assign trial = {cur.rem, cur.nq[WORD_W-1]};
      assign ge    = (trial >= {1'b0, cur.dmag});

      always_comb begin
         nxt       = cur;
         nxt.nq    = {cur.nq[WORD_W-2:0], ge};
         nxt.rem   = ge ? DMAG_W'(trial - {1'b0, cur.dmag}) : trial[DMAG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_ff[k].valid <= 1'b0;
         end else begin
            stg_ff[k].valid <= nxt.valid;
         end
         stg_ff[k].temp <= nxt.temp;
         stg_ff[k].err  <= nxt.err;
         stg_ff[k].neg  <= nxt.neg;
         stg_ff[k].nq   <= nxt.nq;
         stg_ff[k].rem  <= nxt.rem;
         stg_ff[k].dmag <= nxt.dmag;
      end
   end

   always_comb begin
      div_out.valid = stg_ff[DIV_STAGES-1].valid;
      div_out.temp  = stg_ff[DIV_STAGES-1].temp;
      div_out.err   = stg_ff[DIV_STAGES-1].err;
      div_out.neg   = stg_ff[DIV_STAGES-1].neg;
      div_out.quo   = stg_ff[DIV_STAGES-1].nq;
   end

endmodule

// File: hdl/bptc_back.sv
// ----------------------------------------------------------------------------
// bptc_back
// Pressure correction terms after the division, saturation, result register.
// ----------------------------------------------------------------------------
module bptc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bptc_pkg::div_out_type div_in,
   input  bptc_pkg::cal_type     cal,
   output logic                  rsp_valid,
   output bptc_pkg::rsp_type     rsp_data
);
   import bptc_pkg::*;

   logic [BACK_STAGES-1:1] v_ff;
   logic signed [TEMP_W-1:0] temp_ff [1:5];
   logic err_ff [1:5];

   // stage a
   logic [WORD_W-1:0] qa_ff, qa_in;
   // stage b
   logic [WORD_W-1:0] x;
   logic [WORD_W-1:0] qb_ff, xx_lo_ff, xx_lo_in;
   logic [31:0] xx_mid_ff, xx_mid_in, q8_hi_ff, q8_hi_in;
   logic signed [48:0] q8_lo_ff, q8_lo_in;
   // stage c
   logic [WORD_W-1:0] w2full;
   logic [WORD_W-1:0] qc_ff, y_ff, y_in, w2_ff, w2_in;
   // stage d
   logic [WORD_W-1:0] qd_ff, w2d_ff;
   logic signed [48:0] y9_lo_ff, y9_lo_in;
   logic [31:0] y9_hi_ff, y9_hi_in;
   // stage e
   logic [WORD_W-1:0] w1full, w1, s_ff, s_in;
   // stage f
   logic [WORD_W-1:0] ps;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff;

   assign qa_in = div_in.neg ? (-div_in.quo) : div_in.quo;

   // square of q >> 13, kept modulo 2^64
   assign x         = {{13{qa_ff[WORD_W-1]}}, qa_ff[WORD_W-1:13]};
   assign xx_lo_in  = {32'b0, x[31:0]} * {32'b0, x[31:0]};
   assign xx_mid_in = 32'(x[31:0] * x[63:32]);
   assign q8_lo_in  = $signed({1'b0, qa_ff[31:0]}) * $signed(cal.p8);
   assign q8_hi_in  = 32'(qa_ff[63:32] * 32'($signed(cal.p8)));

   assign y_in   = xx_lo_ff + {xx_mid_ff[30:0], 33'b0};
   assign w2full = 64'(q8_lo_ff) + {q8_hi_ff, 32'b0};
   assign w2_in  = {{19{w2full[WORD_W-1]}}, w2full[WORD_W-1:19]};

   assign y9_lo_in = $signed({1'b0, y_ff[31:0]}) * $signed(cal.p9);
   assign y9_hi_in = 32'(y_ff[63:32] * 32'($signed(cal.p9)));

   assign w1full = 64'(y9_lo_ff) + {y9_hi_ff, 32'b0};
   assign w1     = {{25{w1full[WORD_W-1]}}, w1full[WORD_W-1:25]};
   assign s_in   = qd_ff + w1 + w2d_ff;

   assign ps = {{8{s_ff[WORD_W-1]}}, s_ff[WORD_W-1:8]} + (64'($signed(cal.p7)) << 4);

   always_comb begin
      rsp_in.temperature_centi = temp_ff[5];
      rsp_in.divide_error      = err_ff[5];
      if (err_ff[5] || ps[WORD_W-1]) begin
         rsp_in.pressure_q24_8 = '0;
      end else if (|ps[WORD_W-2:PRESS_W]) begin
         rsp_in.pressure_q24_8 = '1;
      end else begin
         rsp_in.pressure_q24_8 = ps[PRESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff         <= {v_ff[BACK_STAGES-2:1], div_in.valid};
         rsp_valid_ff <= v_ff[BACK_STAGES-1];
      end
      temp_ff[1] <= div_in.temp;
      err_ff[1]  <= div_in.err;
      for (int i = 2; i < 6; i++) begin
         temp_ff[i] <= temp_ff[i-1];
         err_ff[i]  <= err_ff[i-1];
      end
      qa_ff     <= qa_in;
      qb_ff     <= qa_ff;
      xx_lo_ff  <= xx_lo_in;
      xx_mid_ff <= xx_mid_in;
      q8_lo_ff  <= q8_lo_in;
      q8_hi_ff  <= q8_hi_in;
      qc_ff     <= qb_ff;
      y_ff      <= y_in;
      w2_ff     <= w2_in;
      qd_ff     <= qc_ff;
      w2d_ff    <= w2_ff;
      y9_lo_ff  <= y9_lo_in;
      y9_hi_ff  <= y9_hi_in;
      s_ff      <= s_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: hdl/baro_temp_pressure_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of raw barometer readings.
// ----------------------------------------------------------------------------
// A request (one raw temperature and one raw pressure reading) is taken on
// every cycle in which start is high; busy is always low. Each request gives
// exactly one result, shown for one cycle with rsp_valid high, after ten
// stages of temperature and coefficient arithmetic, a 64-stage divider
// producing one quotient bit per stage, and six stages of correction,
// saturation and output register. The receiver cannot stall the results,
// and none is held back. The user must write calibration words through the
// csr port only while no request is in flight; the block does not enforce it.
module baro_temp_pressure_compensation (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  bptc_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output bptc_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [bptc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bptc_pkg::CSR_W-1:0]       csr_wdata
);
   import bptc_pkg::*;

   logic [CSR_W-1:0] cal_ff [NUM_CAL];
   cal_type cal;
   div_in_type  front_out;
   div_out_type div_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CAL; i++) cal_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_T1_T2: cal_ff[CSR_T1_T2] <= csr_wdata;
            CSR_T3_P1: cal_ff[CSR_T3_P1] <= csr_wdata;
            CSR_P2_P3: cal_ff[CSR_P2_P3] <= csr_wdata;
            CSR_P4_P5: cal_ff[CSR_P4_P5] <= csr_wdata;
            CSR_P6_P7: cal_ff[CSR_P6_P7] <= csr_wdata;
            CSR_P8_P9: cal_ff[CSR_P8_P9] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = cal_ff[CSR_T1_T2][15:0];
      cal.t2 = cal_ff[CSR_T1_T2][31:16];
      cal.t3 = cal_ff[CSR_T3_P1][15:0];
      cal.p1 = cal_ff[CSR_T3_P1][31:16];
      cal.p2 = cal_ff[CSR_P2_P3][15:0];
      cal.p3 = cal_ff[CSR_P2_P3][31:16];
      cal.p4 = cal_ff[CSR_P4_P5][15:0];
      cal.p5 = cal_ff[CSR_P4_P5][31:16];
      cal.p6 = cal_ff[CSR_P6_P7][15:0];
      cal.p7 = cal_ff[CSR_P6_P7][31:16];
      cal.p8 = cal_ff[CSR_P8_P9][15:0];
      cal.p9 = cal_ff[CSR_P8_P9][31:16];
   end

   assign busy = 1'b0;

   bptc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .cal      (cal),
      .div_out  (front_out)
   );

   bptc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (front_out),
      .div_out (div_out)
   );

   bptc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .div_in    (div_out),
      .cal       (cal),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/bptc_checker.sv
// ----------------------------------------------------------------------------
// bptc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_macros.svh"

module bptc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input bptc_pkg::rsp_type rsp_data
);
   import bptc_pkg::*;

   // each result traces back to an earlier request
   `BPTC_ASSERT(a_rsp_has_request, rsp_valid |-> $past(start && !busy, LATENCY), "result without request")

   // no request is lost once the pipeline is running
   `BPTC_ASSERT(a_request_gives_rsp, $past(start && !busy, LATENCY) && !$past(reset, LATENCY - 1) |-> rsp_valid, "request without result")

   `BPTC_ASSERT(a_div_error_zero, rsp_valid && rsp_data.divide_error |-> rsp_data.pressure_q24_8 == '0, "pressure not zero on divide error")

   `BPTC_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result strobe after reset")

endmodule

bind baro_temp_pressure_compensation bptc_checker u_checker (.*);
